// ===== rtl/pcbd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package pcbd_pkg;

    // Field widths.
    localparam int REQ_W    = 2;
    localparam int BRIGHT_W = 8;
    localparam int KIND_W   = 3;
    localparam int PIDX_W   = 5;
    localparam int LEVEL_W  = 6;

    // Threshold ROM geometry.
    localparam int ROM_LEN = 32;
    localparam int IDX_W   = 5;

    // Default build values.
    localparam int TABLE_STAGES_DEF  = 25;
    localparam int LEVEL_MODULUS_DEF = 32;

    // Mapping constants.
    localparam logic [LEVEL_W-1:0]  DIM_LEVEL   = 6'd32;
    localparam logic [LEVEL_W-1:0]  RESET_LEVEL = 6'd17;
    localparam logic [BRIGHT_W-1:0] DIM_BOUND   = 8'd20;
    localparam logic [BRIGHT_W-1:0] FULL_BRIGHT = 8'd255;
    localparam int                  MAX_PULSES  = 32;

    // Request codes.
    localparam logic [REQ_W-1:0] REQ_SET     = 2'd0;
    localparam logic [REQ_W-1:0] REQ_SUSPEND = 2'd1;
    localparam logic [REQ_W-1:0] REQ_RESUME  = 2'd2;

    // Result kinds.
    localparam logic [KIND_W-1:0] KIND_IGNORED   = 3'd0;
    localparam logic [KIND_W-1:0] KIND_UNCHANGED = 3'd1;
    localparam logic [KIND_W-1:0] KIND_PULSE     = 3'd2;
    localparam logic [KIND_W-1:0] KIND_SHUTDOWN  = 3'd3;
    localparam logic [KIND_W-1:0] KIND_SUSPENDED = 3'd4;
    localparam logic [KIND_W-1:0] KIND_RESUMED   = 3'd5;

    // Job queue depth.
    localparam int QDEPTH = 2;
    localparam int QPTR_W = 1;
    localparam int QCNT_W = 2;

    localparam logic [BRIGHT_W-1:0] BOUND_ROM [ROM_LEN] = '{
        8'd20,  8'd26,  8'd33,  8'd39,  8'd46,  8'd52,  8'd59,  8'd65,
        8'd72,  8'd78,  8'd84,  8'd91,  8'd97,  8'd104, 8'd110, 8'd117,
        8'd123, 8'd140, 8'd156, 8'd173, 8'd189, 8'd206, 8'd222, 8'd239,
        8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255
    };

    localparam logic [LEVEL_W-1:0] LEVEL_NORMAL [ROM_LEN] = '{
        6'd32, 6'd31, 6'd30, 6'd29, 6'd28, 6'd27, 6'd26, 6'd25,
        6'd24, 6'd23, 6'd22, 6'd21, 6'd20, 6'd19, 6'd18, 6'd17,
        6'd16, 6'd15, 6'd14, 6'd13, 6'd12, 6'd11, 6'd10, 6'd9,
        6'd8,  6'd8,  6'd8,  6'd8,  6'd8,  6'd8,  6'd8,  6'd8
    };

    localparam logic [LEVEL_W-1:0] LEVEL_CABC [ROM_LEN] = '{
        6'd32, 6'd31, 6'd31, 6'd30, 6'd30, 6'd29, 6'd28, 6'd27,
        6'd26, 6'd25, 6'd24, 6'd23, 6'd22, 6'd21, 6'd20, 6'd19,
        6'd18, 6'd17, 6'd16, 6'd15, 6'd14, 6'd13, 6'd13, 6'd12,
        6'd11, 6'd11, 6'd11, 6'd11, 6'd11, 6'd11, 6'd11, 6'd11
    };

    // One job for the back end: an optional resumed beat, then a run of
    // last_idx + 1 beats of the given kind.
    typedef struct packed {
        logic               lead;
        logic [LEVEL_W-1:0] lead_level;
        logic [KIND_W-1:0]  kind;
        logic [LEVEL_W-1:0] target;
        logic               pin;
        logic [PIDX_W-1:0]  last_idx;
    } pcbd_job_t;

endpackage

`default_nettype wire

// ===== rtl/pcbd_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface pcbd_req_if import pcbd_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [REQ_W-1:0]    req_type;
    logic [BRIGHT_W-1:0] brightness;

    modport source (output valid, output req_type, output brightness, input ready);
    modport sink (input valid, input req_type, input brightness, output ready);
endinterface

interface pcbd_res_if import pcbd_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [KIND_W-1:0]  kind;
    logic [PIDX_W-1:0]  pulse_index;
    logic [LEVEL_W-1:0] target_level;
    logic               enable_pin;
    logic               last;

    modport source (
        output valid, output kind, output pulse_index, output target_level,
        output enable_pin, output last, input ready
    );
    modport sink (
        input valid, input kind, input pulse_index, input target_level,
        input enable_pin, input last, output ready
    );
endinterface

`default_nettype wire

// ===== rtl/pcbd_front.sv =====
`timescale 1ns / 1ps
`default_nettype none

module pcbd_front import pcbd_pkg::*; #(
    parameter int TABLE_STAGES  = TABLE_STAGES_DEF,
    parameter int LEVEL_MODULUS = LEVEL_MODULUS_DEF
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    pcbd_req_if.sink   req,
    input  wire logic  cabc_enable,
    output pcbd_job_t  job,
    output logic       job_valid,
    input  wire logic  job_ready
);

    localparam int STAGES = (TABLE_STAGES > ROM_LEN) ? ROM_LEN :
                            ((TABLE_STAGES < 1) ? 1 : TABLE_STAGES);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(STAGES - 1);
    localparam logic signed [7:0] MODULUS = 8'(LEVEL_MODULUS);
    localparam logic signed [7:0] PULSE_CAP = 8'(MAX_PULSES);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_EVAL = 2'd2;
    localparam logic [1:0] S_PUSH = 2'd3;

    logic [1:0]          state_reg,   state_next;
    logic [BRIGHT_W-1:0] bright_reg,  bright_next;
    logic [LEVEL_W-1:0]  applied_reg, applied_next;
    logic                active_reg,  active_next;
    logic                enable_reg,  enable_next;
    logic                lead_reg,    lead_next;
    logic [IDX_W-1:0]    idx_reg,     idx_next;
    logic [LEVEL_W-1:0]  tune_reg,    tune_next;
    pcbd_job_t           job_reg,     job_next;

    logic [LEVEL_W-1:0]  scan_level;
    logic [LEVEL_W-1:0]  full_level;
    logic signed [7:0]   diff;
    logic signed [7:0]   pulses;
    logic signed [7:0]   pulses_sat;
    logic [7:0]          run_m1;

    assign scan_level = cabc_enable ? LEVEL_CABC[idx_reg] : LEVEL_NORMAL[idx_reg];
    assign full_level = cabc_enable ? LEVEL_CABC[LAST_IDX] : LEVEL_NORMAL[LAST_IDX];

    // Wrap-around pulse count from the applied level to the new one.
    assign diff       = $signed({2'b00, tune_reg}) - $signed({2'b00, applied_reg});
    assign pulses     = (applied_reg <= tune_reg) ? diff : MODULUS + diff;
    assign pulses_sat = (pulses > PULSE_CAP) ? PULSE_CAP : pulses;
    assign run_m1     = 8'(pulses_sat - 8'sd1);

    assign req.ready = (state_reg == S_IDLE);
    assign job_valid = (state_reg == S_PUSH);
    assign job       = job_reg;

    always_comb
    begin
        state_next   = state_reg;
        bright_next  = bright_reg;
        applied_next = applied_reg;
        active_next  = active_reg;
        enable_next  = enable_reg;
        lead_next    = lead_reg;
        idx_next     = idx_reg;
        tune_next    = tune_reg;
        job_next     = job_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    case (req.req_type)
                        REQ_SET:
                        begin
                            bright_next = req.brightness;
                            if (active_reg)
                            begin
                                lead_next  = 1'b0;
                                idx_next   = '0;
                                state_next = S_SCAN;
                            end
                            else
                            begin
                                job_next   = '{lead: 1'b0, lead_level: applied_reg,
                                               kind: KIND_IGNORED, target: applied_reg,
                                               pin: enable_reg, last_idx: '0};
                                state_next = S_PUSH;
                            end
                        end
                        REQ_SUSPEND:
                        begin
                            active_next  = 1'b0;
                            enable_next  = 1'b0;
                            applied_next = '0;
                            job_next     = '{lead: 1'b0, lead_level: '0,
                                             kind: KIND_SUSPENDED, target: '0,
                                             pin: 1'b0, last_idx: '0};
                            state_next   = S_PUSH;
                        end
                        REQ_RESUME:
                        begin
                            active_next = 1'b1;
                            enable_next = 1'b1;
                            lead_next   = 1'b1;
                            idx_next    = '0;
                            state_next  = S_SCAN;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_SCAN:
            begin
                if (bright_reg == '0)
                begin
                    tune_next  = '0;
                    state_next = S_EVAL;
                end
                else if (bright_reg < DIM_BOUND)
                begin
                    tune_next  = DIM_LEVEL;
                    state_next = S_EVAL;
                end
                else if (bright_reg == FULL_BRIGHT)
                begin
                    tune_next  = full_level;
                    state_next = S_EVAL;
                end
                else if (bright_reg <= BOUND_ROM[idx_reg])
                begin
                    tune_next  = scan_level;
                    state_next = S_EVAL;
                end
                else if (idx_reg == LAST_IDX)
                begin
                    tune_next  = '0;
                    state_next = S_EVAL;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            S_EVAL:
            begin
                job_next.lead       = lead_reg;
                job_next.lead_level = applied_reg;
                job_next.target     = tune_reg;
                job_next.last_idx   = '0;
                if (tune_reg == applied_reg || (tune_reg != '0 && pulses <= 8'sd0))
                begin
                    job_next.kind = KIND_UNCHANGED;
                    job_next.pin  = enable_reg;
                end
                else if (tune_reg == '0)
                begin
                    enable_next     = 1'b0;
                    applied_next    = '0;
                    job_next.kind   = KIND_SHUTDOWN;
                    job_next.pin    = 1'b0;
                end
                else
                begin
                    enable_next       = 1'b1;
                    applied_next      = tune_reg;
                    job_next.kind     = KIND_PULSE;
                    job_next.pin      = 1'b1;
                    job_next.last_idx = run_m1[PIDX_W-1:0];
                end
                state_next = S_PUSH;
            end
            S_PUSH:
            begin
                if (job_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            bright_reg  <= '0;
            applied_reg <= RESET_LEVEL;
            active_reg  <= 1'b1;
            enable_reg  <= 1'b1;
            lead_reg    <= 1'b0;
            idx_reg     <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            bright_reg  <= bright_next;
            applied_reg <= applied_next;
            active_reg  <= active_next;
            enable_reg  <= enable_next;
            lead_reg    <= lead_next;
            idx_reg     <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        tune_reg <= tune_next;
        job_reg  <= job_next;
    end

endmodule

`default_nettype wire

// ===== rtl/pcbd_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none

module pcbd_queue import pcbd_pkg::*; (
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire pcbd_job_t push_job,
    input  wire logic      push_valid,
    output logic           push_ready,
    output pcbd_job_t      pop_job,
    output logic           pop_valid,
    input  wire logic      pop_ready
);

    pcbd_job_t          entry_reg [QDEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0]  count_reg;
    logic               do_push, do_pop;

    assign push_ready = (count_reg != QCNT_W'(QDEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_job    = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

// ===== rtl/pcbd_back.sv =====
`timescale 1ns / 1ps
`default_nettype none

module pcbd_back import pcbd_pkg::*; (
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire pcbd_job_t pop_job,
    input  wire logic      pop_valid,
    output logic           pop_ready,
    pcbd_res_if.source     res
);

    logic               busy_reg;
    logic               lead_reg;
    logic [PIDX_W-1:0]  idx_reg;
    pcbd_job_t          job_reg;

    logic               out_valid_reg;
    logic [KIND_W-1:0]  kind_reg;
    logic [PIDX_W-1:0]  pidx_reg;
    logic [LEVEL_W-1:0] target_reg;
    logic               pin_reg;
    logic               last_reg;

    logic               emit;
    logic               run_end;

    assign pop_ready = !busy_reg;
    assign emit      = busy_reg && (!out_valid_reg || res.ready);
    assign run_end   = (idx_reg == job_reg.last_idx);

    assign res.valid        = out_valid_reg;
    assign res.kind         = kind_reg;
    assign res.pulse_index  = pidx_reg;
    assign res.target_level = target_reg;
    assign res.enable_pin   = pin_reg;
    assign res.last         = last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            lead_reg      <= 1'b0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (!busy_reg && pop_valid)
            begin
                busy_reg <= 1'b1;
                lead_reg <= pop_job.lead;
                idx_reg  <= '0;
            end
            else if (emit)
            begin
                if (lead_reg)
                begin
                    lead_reg <= 1'b0;
                end
                else if (run_end)
                begin
                    busy_reg <= 1'b0;
                end
                else
                begin
                    idx_reg <= idx_reg + 1'b1;
                end
            end

            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (res.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (!busy_reg && pop_valid)
        begin
            job_reg <= pop_job;
        end
        if (emit)
        begin
            if (lead_reg)
            begin
                kind_reg   <= KIND_RESUMED;
                pidx_reg   <= '0;
                target_reg <= job_reg.lead_level;
                pin_reg    <= 1'b1;
                last_reg   <= 1'b0;
            end
            else
            begin
                kind_reg   <= job_reg.kind;
                pidx_reg   <= (job_reg.kind == KIND_PULSE) ? idx_reg : '0;
                target_reg <= job_reg.target;
                pin_reg    <= job_reg.pin;
                last_reg   <= run_end;
            end
        end
    end

endmodule

`default_nettype wire

// ===== rtl/pulse_count_backlight_dimmer.sv =====
`timescale 1ns / 1ps
`default_nettype none

// A scanning request (set while resumed, or resume) is accepted in S_IDLE, scans the table in S_SCAN,
// is evaluated in S_EVAL and pushed to the queue from S_PUSH; the back end registers each beat.
// The front end takes no new request until its job is queued, and an unused code gives no job; the
// back end sends one beat per cycle while the receiver is ready, up to 33 per request, and takes
// no new job until the last is done. Reset (rst_n, asynchronous, active low) empties the queue and
// output, selects the normal table; the block wakes resumed, line high, level 17, brightness 0.

module pulse_count_backlight_dimmer import pcbd_pkg::*; #(
    parameter int TABLE_STAGES  = TABLE_STAGES_DEF,
    parameter int LEVEL_MODULUS = LEVEL_MODULUS_DEF
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    pcbd_req_if.sink   req,
    pcbd_res_if.source res,
    input  wire logic  cfg_we,
    input  wire logic  cfg_wdata
);

    // Table select register; the user must write it only while the block is idle, the block does not enforce it.
    logic cabc_enable_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cabc_enable_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            cabc_enable_reg <= cfg_wdata;
        end
    end

    pcbd_job_t push_job;
    logic      push_valid;
    logic      push_ready;
    pcbd_job_t pop_job;
    logic      pop_valid;
    logic      pop_ready;

    // The front end owns all request state and turns each request but the unused code into one job.
    pcbd_front #(
        .TABLE_STAGES  (TABLE_STAGES),
        .LEVEL_MODULUS (LEVEL_MODULUS)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .req         (req),
        .cabc_enable (cabc_enable_reg),
        .job         (push_job),
        .job_valid   (push_valid),
        .job_ready   (push_ready)
    );

    // A two-entry queue lets the front end scan the next request while the
    // back end is still stalled on the output.
    pcbd_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_job   (push_job),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .pop_job    (pop_job),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready)
    );

    // The back end expands each job into its beats through an output register.
    pcbd_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_job   (pop_job),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .res       (res)
    );

endmodule

`default_nettype wire

// ===== verif/tb_pulse_count_backlight_dimmer.sv =====
`timescale 1ns / 1ps

module tb_pulse_count_backlight_dimmer;
    import pcbd_pkg::*;

    // The block is built with its default table depth and level modulus, and the
    // predictor below uses the very same values.
    localparam int TABLE_STAGES  = TABLE_STAGES_DEF;
    localparam int LEVEL_MODULUS = LEVEL_MODULUS_DEF;

    // The one request code that the block does not define; it must be swallowed.
    localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;

    // Cycles to let pass once the last expected beat has come, so that a request
    // which gives no beat has surely left the scan and the job queue.
    localparam int DRAIN_CYCLES   = 4 * (TABLE_STAGES + 8);
    // Cycles without any handshake on either side before the run is abandoned.
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int RANDOM_PER_SEG = 33;
    localparam int NUM_SEGS       = 6;

    typedef struct packed {
        logic [REQ_W-1:0]    req_type;
        logic [BRIGHT_W-1:0] brightness;
    } request_t;

    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [PIDX_W-1:0]  pulse_index;
        logic [LEVEL_W-1:0] target_level;
        logic               enable_pin;
        logic               last;
    } beat_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we;
    logic cfg_wdata;

    pcbd_req_if req_ch ();
    pcbd_res_if res_ch ();

    pulse_count_backlight_dimmer #(
        .TABLE_STAGES  (TABLE_STAGES),
        .LEVEL_MODULUS (LEVEL_MODULUS)
    ) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req_ch),
        .res       (res_ch),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    // 8 ns period.
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Requests still to be offered to the block, and the beats that the
    // accepted requests are predicted to give, oldest first.
    request_t request_backlog [$];
    beat_t    beat_queue [$];

    int issued_items   = 0;
    int accepted_items = 0;
    int fault_count    = 0;
    int idle_cycles    = 0;

    // Percentages of cycles in which the sender holds back and the receiver
    // refuses a beat.
    int send_idle_pct = 0;
    int recv_idle_pct = 0;

    // Our own copy of the dimmer state, kept in step with the accepted requests.
    logic                cabc_model;
    logic [BRIGHT_W-1:0] stored_bright;
    logic [LEVEL_W-1:0]  applied_lvl;
    logic                resumed;
    logic                pin_state;

    beat_t want_beat;
    beat_t got_beat;

    // Brightness to chip level: zero switches off, the very dim values give the
    // top of the count, full brightness takes the last scanned entry and every
    // other value the first entry whose bound is not below it. A value above
    // the last scanned bound falls through to zero.
    function automatic logic [LEVEL_W-1:0] chip_level(input logic [BRIGHT_W-1:0] b);
        int stages;
        int i;
        logic [LEVEL_W-1:0] lvl;
        stages = (TABLE_STAGES > ROM_LEN) ? ROM_LEN : TABLE_STAGES;
        if (stages < 1)
            stages = 1;
        lvl = '0;
        if (b == '0)
            lvl = '0;
        else if (b < DIM_BOUND)
            lvl = DIM_LEVEL;
        else if (b == FULL_BRIGHT)
            lvl = cabc_model ? LEVEL_CABC[stages-1] : LEVEL_NORMAL[stages-1];
        else
        begin
            for (i = stages - 1; i >= 0; i--)
            begin
                if (b <= BOUND_ROM[i])
                    lvl = cabc_model ? LEVEL_CABC[i] : LEVEL_NORMAL[i];
            end
        end
        return lvl;
    endfunction

    function automatic void add_beat(input logic [KIND_W-1:0] kind,
                                     input logic [PIDX_W-1:0] idx,
                                     input logic [LEVEL_W-1:0] lvl,
                                     input logic pin, input logic last);
        beat_t b;
        b.kind         = kind;
        b.pulse_index  = idx;
        b.target_level = lvl;
        b.enable_pin   = pin;
        b.last         = last;
        beat_queue.push_back(b);
    endfunction

    // Drives the chip towards the level of brightness b: an unchanged beat if it
    // is already there, a shutdown for level zero, otherwise a run of wrap-around
    // pulses, at most MAX_PULSES long.
    function automatic void apply_brightness(input logic [BRIGHT_W-1:0] b);
        logic [LEVEL_W-1:0] tune;
        int cur;
        int pulses;
        int n;
        int i;
        tune = chip_level(b);
        cur  = int'(applied_lvl);
        if (tune == applied_lvl)
            add_beat(KIND_UNCHANGED, '0, tune, pin_state, 1'b1);
        else if (tune == '0)
        begin
            pin_state   = 1'b0;
            applied_lvl = '0;
            add_beat(KIND_SHUTDOWN, '0, '0, 1'b0, 1'b1);
        end
        else
        begin
            if (cur <= int'(tune))
                pulses = int'(tune) - cur;
            else
                pulses = LEVEL_MODULUS - (cur - int'(tune));
            if (pulses <= 0)
                add_beat(KIND_UNCHANGED, '0, tune, pin_state, 1'b1);
            else
            begin
                n           = (pulses > MAX_PULSES) ? MAX_PULSES : pulses;
                pin_state   = 1'b1;
                applied_lvl = tune;
                for (i = 0; i < n; i++)
                    add_beat(KIND_PULSE, PIDX_W'(i), tune, 1'b1, i == n - 1);
            end
        end
    endfunction

    // Works out every beat that one accepted request gives and moves the
    // model state on.
    function automatic void predict_request(input logic [REQ_W-1:0] rt,
                                            input logic [BRIGHT_W-1:0] b);
        case (rt)
            REQ_SET:
            begin
                stored_bright = b;
                if (!resumed)
                    add_beat(KIND_IGNORED, '0, applied_lvl, pin_state, 1'b1);
                else
                    apply_brightness(b);
            end
            REQ_SUSPEND:
            begin
                resumed     = 1'b0;
                pin_state   = 1'b0;
                applied_lvl = '0;
                add_beat(KIND_SUSPENDED, '0, '0, 1'b0, 1'b1);
            end
            REQ_RESUME:
            begin
                resumed   = 1'b1;
                pin_state = 1'b1;
                add_beat(KIND_RESUMED, '0, applied_lvl, 1'b1, 1'b0);
                apply_brightness(stored_bright);
            end
            default:
            begin
                // The unused code is swallowed without a beat.
            end
        endcase
    endfunction

    function automatic void note_fault(input string msg);
        fault_count++;
        if (fault_count <= 10)
            $display("%s", msg);
    endfunction

    // Random requests lean towards set-brightness, with enough suspends and
    // resumes to keep moving between the two modes. Brightness is weighted
    // towards zero, the dim band, full scale and the table bounds, where the
    // mapping has its corners.
    function automatic request_t random_request();
        request_t r;
        int sel;
        sel = $urandom_range(99);
        if (sel < 66)
            r.req_type = REQ_SET;
        else if (sel < 78)
            r.req_type = REQ_SUSPEND;
        else if (sel < 92)
            r.req_type = REQ_RESUME;
        else
            r.req_type = REQ_UNUSED;
        sel = $urandom_range(99);
        if (sel < 6)
            r.brightness = '0;
        else if (sel < 20)
            r.brightness = BRIGHT_W'($urandom_range(19, 1));
        else if (sel < 28)
            r.brightness = FULL_BRIGHT;
        else if (sel < 40)
            r.brightness = BOUND_ROM[$urandom_range(24)] + BRIGHT_W'($urandom_range(1));
        else
            r.brightness = BRIGHT_W'($urandom_range(255));
        return r;
    endfunction

    task automatic queue_request(input logic [REQ_W-1:0] rt, input logic [BRIGHT_W-1:0] b);
        request_t r;
        r.req_type   = rt;
        r.brightness = b;
        request_backlog.push_back(r);
        issued_items++;
    endtask

    // Waits until every queued request has been taken and every predicted beat
    // has arrived, then lets the pipeline drain of requests that gave none.
    task automatic settle();
        while (accepted_items != issued_items || beat_queue.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Register write, only ever issued while the block is idle. The model takes
    // the new value at the edge where the block samples the write.
    task automatic write_cabc(input logic value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we     <= 1'b0;
        cabc_model  = value;
    endtask

    // Request driver. A request on offer is held until the block takes it; only
    // then may the next one be put up or the line fall idle, so valid changes
    // at most once per edge.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_ch.valid      <= 1'b0;
            req_ch.req_type   <= '0;
            req_ch.brightness <= '0;
        end
        else if (!req_ch.valid || req_ch.ready)
        begin
            if (request_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                req_ch.valid      <= 1'b1;
                req_ch.req_type   <= request_backlog[0].req_type;
                req_ch.brightness <= request_backlog[0].brightness;
                void'(request_backlog.pop_front());
            end
            else
                req_ch.valid <= 1'b0;
        end
    end

    // Result receiver: ready is thrown at random every cycle.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_ch.ready <= 1'b0;
        else
            res_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Monitor. An accepted request is run through the predictor at the edge
    // that takes it; an accepted result beat is matched against the oldest
    // prediction. Values are sampled before the edge's own updates land.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (req_ch.valid && req_ch.ready)
            begin
                predict_request(req_ch.req_type, req_ch.brightness);
                accepted_items++;
            end
            if (res_ch.valid && res_ch.ready)
            begin
                got_beat.kind         = res_ch.kind;
                got_beat.pulse_index  = res_ch.pulse_index;
                got_beat.target_level = res_ch.target_level;
                got_beat.enable_pin   = res_ch.enable_pin;
                got_beat.last         = res_ch.last;
                if (beat_queue.size() == 0)
                    note_fault($sformatf(
                        "unexpected beat: kind %0d idx %0d level %0d pin %0b last %0b",
                        got_beat.kind, got_beat.pulse_index, got_beat.target_level,
                        got_beat.enable_pin, got_beat.last));
                else
                begin
                    want_beat = beat_queue.pop_front();
                    if (got_beat !== want_beat)
                        note_fault($sformatf({"beat mismatch: expected kind %0d idx %0d ",
                            "level %0d pin %0b last %0b, got kind %0d idx %0d level %0d ",
                            "pin %0b last %0b"},
                            want_beat.kind, want_beat.pulse_index, want_beat.target_level,
                            want_beat.enable_pin, want_beat.last,
                            got_beat.kind, got_beat.pulse_index, got_beat.target_level,
                            got_beat.enable_pin, got_beat.last));
                end
            end
        end
    end

    // Watchdog: a long stretch with no handshake at all means the block is hung.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    initial
    begin : stimulus
        int seg;
        int k;
        int seg_send [NUM_SEGS];
        int seg_recv [NUM_SEGS];
        logic seg_cabc [NUM_SEGS];
        request_t r;

        // The receiver is the sparse side first, then the sender, then neither
        // side holds back; the table choice flips inside each pair.
        seg_send = '{22, 22, 81, 81, 0, 0};
        seg_recv = '{81, 81, 22, 22, 0, 0};
        seg_cabc = '{1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1};

        req_ch.valid      = 1'b0;
        req_ch.req_type   = '0;
        req_ch.brightness = '0;
        res_ch.ready      = 1'b0;
        cfg_we            = 1'b0;
        cfg_wdata         = 1'b0;

        // Model state as the block leaves reset: resumed, line high, level 17.
        cabc_model    = 1'b0;
        stored_bright = '0;
        applied_lvl   = RESET_LEVEL;
        resumed       = 1'b1;
        pin_state     = 1'b1;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        send_idle_pct = seg_send[0];
        recv_idle_pct = seg_recv[0];
        write_cabc(1'b0);

        // Directed requests on the normal table. Zero brightness from the reset
        // level is a shutdown; the climb back from zero to the top of the count
        // is the longest pulse run; dim values and the first bound land on the
        // level already applied; one step down wraps almost all the way round.
        queue_request(REQ_SET, 8'd0);
        queue_request(REQ_SET, 8'd1);
        queue_request(REQ_SET, 8'd19);
        queue_request(REQ_SET, 8'd20);
        queue_request(REQ_SET, 8'd21);
        queue_request(REQ_SET, FULL_BRIGHT);
        queue_request(REQ_SET, 8'd254);
        queue_request(REQ_SET, 8'd239);
        queue_request(REQ_UNUSED, 8'hff);
        // A set while suspended is only stored; suspending twice repeats the
        // beat; resuming twice reapplies the stored value each time.
        queue_request(REQ_SUSPEND, 8'h00);
        queue_request(REQ_SET, 8'd100);
        queue_request(REQ_SUSPEND, 8'haa);
        queue_request(REQ_RESUME, 8'h55);
        queue_request(REQ_RESUME, 8'h00);
        queue_request(REQ_SET, 8'd123);
        queue_request(REQ_SET, 8'd124);
        settle();

        // The adaptive-contrast table, with a resume that reapplies zero from a
        // suspended, already dark chip.
        write_cabc(1'b1);
        queue_request(REQ_SET, FULL_BRIGHT);
        queue_request(REQ_SET, 8'd33);
        queue_request(REQ_SET, 8'd26);
        queue_request(REQ_SET, 8'd0);
        queue_request(REQ_RESUME, 8'hff);
        queue_request(REQ_SUSPEND, 8'h0f);
        queue_request(REQ_SET, 8'd0);
        queue_request(REQ_RESUME, 8'hf0);
        settle();

        for (seg = 0; seg < NUM_SEGS; seg++)
        begin
            write_cabc(seg_cabc[seg]);
            send_idle_pct = seg_send[seg];
            recv_idle_pct = seg_recv[seg];
            for (k = 0; k < RANDOM_PER_SEG; k++)
            begin
                r = random_request();
                queue_request(r.req_type, r.brightness);
            end
            settle();
        end

        if (fault_count == 0 && beat_queue.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/pcbd_pkg.sv
rtl/pcbd_if.sv
rtl/pcbd_front.sv
rtl/pcbd_queue.sv
rtl/pcbd_back.sv
rtl/pulse_count_backlight_dimmer.sv
verif/tb_pulse_count_backlight_dimmer.sv
